/* hdl/lsm_pkg.sv */
// Shared types, constants and codes for the laser sector minimum block.
// No dependencies; every other file in hdl/ imports this package.
package lsm_pkg;

  // Default sizing of the top level
  localparam int LSM_MAX_SAMPLES = 1024;
  localparam int LSM_RANGE_BITS  = 16;

  // Fixed field widths
  localparam int RANGE_W = 16;   // range_sample field
  localparam int FRONT_W = 17;   // front_distance field
  localparam int START_W = 20;   // start_angle register
  localparam int STEP_W  = 17;   // angle_step register
  localparam int WIDTH_W = 19;   // sector_width register
  localparam int CFG_W   = 20;   // widest register
  localparam int BND_W   = 21;   // signed sector bound
  localparam int NSECT   = 5;
  localparam int NEAR_LIMIT = 30;

  // Angles in Q4.16 radians
  localparam logic signed [BND_W-1:0] Q_PI_4  = 21'sd51472;
  localparam logic signed [BND_W-1:0] Q_PI_2  = 21'sd102944;
  localparam logic signed [BND_W-1:0] Q_3PI_2 = 21'sd308831;
  localparam logic signed [BND_W-1:0] Q_7PI_4 = 21'sd360303;
  localparam logic signed [BND_W-1:0] Q_2PI   = 21'sd411775;

  // Sector centres: front, front left, front right, left, right
  localparam logic signed [BND_W-1:0] SECT_CENTRE [NSECT] =
    '{21'sd0, Q_PI_4, Q_7PI_4, Q_PI_2, Q_3PI_2};

  // Register indexes
  typedef enum logic [1:0] {
    CFG_START_ANGLE  = 2'd0,
    CFG_ANGLE_STEP   = 2'd1,
    CFG_SECTOR_WIDTH = 2'd2
  } cfg_idx_e;

  localparam logic signed [START_W-1:0] START_RST = '0;
  localparam logic [STEP_W-1:0]         STEP_RST  = 17'd1144;
  localparam logic [WIDTH_W-1:0]        WIDTH_RST = 19'd32768;

  // One sector window
  typedef struct packed {
    logic signed [BND_W-1:0] lo;
    logic signed [BND_W-1:0] hi;
  } bound_t;

  typedef bound_t [NSECT-1:0] bounds_t;

  // Per-sample flags carried from the angle stage to the tracker
  typedef struct packed {
    logic last;   // final sample of the scan
    logic near;   // sample index below NEAR_LIMIT
  } smp_flags_t;

endpackage

/* hdl/laser_sector_minimum_core.sv */
// Laser sector minimum: top level with configuration registers and stream ports.
// Depends on lsm_pkg, lsm_bounds, lsm_angle, lsm_tracker.
//
//  channel    | direction | beat contents
//  -----------+-----------+-----------------------------------------------------
//  s_axis     | in        | one range sample; tlast marks the final sample
//  m_axis     | out       | five sector minima and empty flags, once per scan
//  cfg        | in        | register write: start_angle, angle_step, sector_width
//
// One sample per cycle is accepted while no last beat waits on a stalled
// result. The last sample passes the input register (angle multiply-add), then
// the sector compare and minimum update into the result register.
// Reset clears the sample index, sector state and both valid flags.
// A stalled result only holds back the input when a further last beat must
// load it; ordinary samples keep flowing.
module laser_sector_minimum_core #(
  parameter int MAX_SAMPLES = lsm_pkg::LSM_MAX_SAMPLES,
  parameter int RANGE_BITS  = lsm_pkg::LSM_RANGE_BITS
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [1:0]                  cfg_idx_i,
  input  logic [lsm_pkg::CFG_W-1:0]   cfg_data_i,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [15:0]                 s_axis_tdata,  // [15:0] range_sample
  input  logic                        s_axis_tlast,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // [16:0] front_distance, [32:17] front_left_distance,
  // [48:33] front_right_distance, [64:49] left_distance,
  // [80:65] right_distance, [85:81] empty_sectors, [87:86] zero
  output logic [87:0]                 m_axis_tdata
);
  import lsm_pkg::*;

  localparam int RW    = (RANGE_BITS < RANGE_W) ? RANGE_BITS : RANGE_W;
  localparam int ANG_W = $clog2(MAX_SAMPLES) + STEP_W + 2;

  logic signed [START_W-1:0] start_q;
  logic [STEP_W-1:0]         step_q;
  logic [WIDTH_W-1:0]        width_q;
  bounds_t                   bounds;
  logic                      b_valid, b_advance;
  logic signed [ANG_W-1:0]   b_angle;
  logic [RW-1:0]             b_range;
  smp_flags_t                b_flags;
  logic [FRONT_W-1:0]        front;
  logic [RANGE_W-1:0]        front_left, front_right, left_d, right_d;
  logic [NSECT-1:0]          empty;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= START_RST;
      step_q  <= STEP_RST;
      width_q <= WIDTH_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_START_ANGLE:  start_q <= $signed(cfg_data_i[START_W-1:0]);
        CFG_ANGLE_STEP:   step_q  <= cfg_data_i[STEP_W-1:0];
        CFG_SECTOR_WIDTH: width_q <= cfg_data_i[WIDTH_W-1:0];
        default: ;
      endcase
    end
  end

  lsm_bounds u_bounds (
    .clk_i          (clk_i),
    .sector_width_i (width_q),
    .bounds_o       (bounds)
  );

  lsm_angle #(
    .MAX_SAMPLES (MAX_SAMPLES),
    .RW          (RW),
    .ANG_W       (ANG_W)
  ) u_angle (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_angle_i (start_q),
    .angle_step_i  (step_q),
    .s_valid_i     (s_axis_tvalid),
    .s_range_i     (s_axis_tdata),
    .s_last_i      (s_axis_tlast),
    .s_ready_o     (s_axis_tready),
    .b_valid_o     (b_valid),
    .b_angle_o     (b_angle),
    .b_range_o     (b_range),
    .b_flags_o     (b_flags),
    .b_advance_i   (b_advance)
  );

  lsm_tracker #(
    .RW    (RW),
    .ANG_W (ANG_W)
  ) u_tracker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .bounds_i        (bounds),
    .b_valid_i       (b_valid),
    .b_angle_i       (b_angle),
    .b_range_i       (b_range),
    .b_flags_i       (b_flags),
    .b_advance_o     (b_advance),
    .m_valid_o       (m_axis_tvalid),
    .m_ready_i       (m_axis_tready),
    .m_front_o       (front),
    .m_front_left_o  (front_left),
    .m_front_right_o (front_right),
    .m_left_o        (left_d),
    .m_right_o       (right_d),
    .m_empty_o       (empty)
  );

  assign m_axis_tdata = {2'b00, empty, right_d, left_d, front_right, front_left, front};

endmodule

/* hdl/lsm_bounds.sv */
// Sector window bounds, registered from the sector_width register.
// Depends on lsm_pkg.
module lsm_bounds (
  input  logic                          clk_i,
  input  logic [lsm_pkg::WIDTH_W-1:0]   sector_width_i,
  output lsm_pkg::bounds_t              bounds_o
);
  import lsm_pkg::*;

  bounds_t                 bounds_d, bounds_q;
  logic signed [BND_W-1:0] half;
  logic signed [BND_W-1:0] lo, hi;

  // Wrap negative bounds by 2pi; clip the bounds of every sector to the front half
  always_comb begin
    half = $signed({3'b000, sector_width_i[WIDTH_W-1:1]});
    bounds_d = '0;
    for (int j = 0; j < NSECT; j++) begin
      lo = SECT_CENTRE[j] - half;
      hi = SECT_CENTRE[j] + half;
      if (lo < 0) begin
        lo = lo + Q_2PI;
      end else if (lo > Q_PI_2 && lo < Q_3PI_2) begin
        lo = Q_3PI_2;
      end
      if (hi < 0) begin
        hi = hi + Q_2PI;
      end else if (hi > Q_PI_2 && hi < Q_3PI_2) begin
        hi = Q_PI_2;
      end
      bounds_d[j].lo = lo;
      bounds_d[j].hi = hi;
    end
  end

  // Payload register, follows configuration in the next cycle
  always_ff @(posedge clk_i) begin
    bounds_q <= bounds_d;
  end

  assign bounds_o = bounds_q;

endmodule

/* hdl/lsm_angle.sv */
// Input stage: sample index counter, angle multiply-add and input register.
// Depends on lsm_pkg.
module lsm_angle #(
  parameter int MAX_SAMPLES = lsm_pkg::LSM_MAX_SAMPLES,
  parameter int RW          = lsm_pkg::LSM_RANGE_BITS,
  parameter int ANG_W       = $clog2(MAX_SAMPLES) + lsm_pkg::STEP_W + 2
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic signed [lsm_pkg::START_W-1:0]   start_angle_i,
  input  logic [lsm_pkg::STEP_W-1:0]           angle_step_i,
  input  logic                                 s_valid_i,
  input  logic [lsm_pkg::RANGE_W-1:0]          s_range_i,
  input  logic                                 s_last_i,
  output logic                                 s_ready_o,
  output logic                                 b_valid_o,
  output logic signed [ANG_W-1:0]              b_angle_o,
  output logic [RW-1:0]                        b_range_o,
  output lsm_pkg::smp_flags_t                  b_flags_o,
  input  logic                                 b_advance_i
);
  import lsm_pkg::*;

  localparam int IDX_W  = $clog2(MAX_SAMPLES);
  localparam int PROD_W = IDX_W + STEP_W;

  logic [IDX_W-1:0]        count_d, count_q;
  logic [PROD_W-1:0]       prod;
  logic signed [ANG_W-1:0] angle_d, angle_q;
  logic [RW-1:0]           range_q;
  smp_flags_t              flags_d, flags_q;
  logic                    valid_d, valid_q;
  logic                    s_fire;

  assign s_ready_o = !valid_q || b_advance_i;
  assign s_fire    = s_valid_i && s_ready_o;

  // Angle of this beat: start + index * step
  always_comb begin
    prod    = PROD_W'(count_q) * PROD_W'(angle_step_i);
    angle_d = ANG_W'(start_angle_i) + $signed(ANG_W'(prod));
    flags_d.last = s_last_i;
    flags_d.near = (32'(count_q) < 32'(NEAR_LIMIT));
  end

  // Index saturates; clears after the last beat of a scan
  always_comb begin
    count_d = count_q;
    if (s_fire) begin
      if (s_last_i) begin
        count_d = '0;
      end else if (count_q != IDX_W'(MAX_SAMPLES - 1)) begin
        count_d = count_q + 1'b1;
      end
    end
    valid_d = s_fire ? 1'b1 : (b_advance_i ? 1'b0 : valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      valid_q <= valid_d;
    end
  end

  // Input payload register
  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      angle_q <= angle_d;
      range_q <= s_range_i[RW-1:0];
      flags_q <= flags_d;
    end
  end

  assign b_valid_o = valid_q;
  assign b_angle_o = angle_q;
  assign b_range_o = range_q;
  assign b_flags_o = flags_q;

endmodule

/* hdl/lsm_tracker.sv */
// Per-sector minimum tracking and the result register.
// Depends on lsm_pkg.
module lsm_tracker #(
  parameter int RW    = lsm_pkg::LSM_RANGE_BITS,
  parameter int ANG_W = 22
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  lsm_pkg::bounds_t                   bounds_i,
  input  logic                               b_valid_i,
  input  logic signed [ANG_W-1:0]            b_angle_i,
  input  logic [RW-1:0]                      b_range_i,
  input  lsm_pkg::smp_flags_t                b_flags_i,
  output logic                               b_advance_o,
  output logic                               m_valid_o,
  input  logic                               m_ready_i,
  output logic [lsm_pkg::FRONT_W-1:0]        m_front_o,
  output logic [lsm_pkg::RANGE_W-1:0]        m_front_left_o,
  output logic [lsm_pkg::RANGE_W-1:0]        m_front_right_o,
  output logic [lsm_pkg::RANGE_W-1:0]        m_left_o,
  output logic [lsm_pkg::RANGE_W-1:0]        m_right_o,
  output logic [lsm_pkg::NSECT-1:0]          m_empty_o
);
  import lsm_pkg::*;

  logic [RW-1:0]          min_q   [NSECT];
  logic [RW-1:0]          min_d   [NSECT];
  logic [NSECT-1:0]       found_q, found_d;
  logic [NSECT-1:0]       in_sec, upd;
  logic                   near_q, near_d;
  logic signed [ANG_W-1:0] lo_x, hi_x;
  logic                   out_free, load;
  logic [FRONT_W-1:0]     front_d;
  logic                   m_valid_q;
  logic [FRONT_W-1:0]     front_q;
  logic [RANGE_W-1:0]     side_q  [1:NSECT-1];
  logic [NSECT-1:0]       empty_q;

  assign out_free    = !m_valid_q || m_ready_i;
  assign b_advance_o = b_valid_i && (!b_flags_i.last || out_free);
  assign load        = b_advance_o && b_flags_i.last;

  // Window test and minimum update for each sector
  always_comb begin
    for (int j = 0; j < NSECT; j++) begin
      lo_x = ANG_W'(bounds_i[j].lo);
      hi_x = ANG_W'(bounds_i[j].hi);
      if (lo_x < hi_x) begin
        in_sec[j] = (lo_x <= b_angle_i) && (b_angle_i <= hi_x);
      end else begin
        in_sec[j] = (lo_x <= b_angle_i) || (b_angle_i <= hi_x);
      end
      upd[j]     = in_sec[j] && (!found_q[j] || b_range_i < min_q[j]);
      found_d[j] = found_q[j] || in_sec[j];
      min_d[j]   = upd[j] ? b_range_i : min_q[j];
    end
    near_d = upd[0] ? b_flags_i.near : near_q;
  end

  // Front result, negated when set near the start of the scan
  always_comb begin
    front_d = found_d[0] ? FRONT_W'(min_d[0]) : '0;
    if (near_d && found_d[0]) begin
      front_d = FRONT_W'(-front_d);
    end
  end

  // Scan state: cleared once the result is taken into the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q   <= '0;
      near_q    <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      if (b_advance_o) begin
        found_q <= b_flags_i.last ? '0 : found_d;
        near_q  <= b_flags_i.last ? 1'b0 : near_d;
      end
      if (load) begin
        m_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // Minima and result payload
  always_ff @(posedge clk_i) begin
    if (b_advance_o) begin
      for (int j = 0; j < NSECT; j++) begin
        min_q[j] <= min_d[j];
      end
    end
    if (load) begin
      front_q <= front_d;
      for (int j = 1; j < NSECT; j++) begin
        side_q[j] <= found_d[j] ? RANGE_W'(min_d[j]) : '0;
      end
      empty_q <= ~found_d;
    end
  end

  assign m_valid_o       = m_valid_q;
  assign m_front_o       = front_q;
  assign m_front_left_o  = side_q[1];
  assign m_front_right_o = side_q[2];
  assign m_left_o        = side_q[3];
  assign m_right_o       = side_q[4];
  assign m_empty_o       = empty_q;

  // A new result only appears after a last beat left the input register
  a_result_from_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> $past(load))
    else $error("result appeared without a last beat");

  // An empty front sector reports zero distance
  a_empty_front_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && empty_q[0]) |-> (front_q == '0))
    else $error("empty front sector with nonzero distance");

  // Scan state is clear after a result is loaded
  a_scan_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> (found_q == '0 && !near_q))
    else $error("sector state not cleared after scan end");

endmodule
